### design/pst_pkg.sv
package pst_pkg;

  // Datapath sizing.
  localparam int VALUE_BITS      = 32;
  localparam int LINE_BITS       = 16;
  localparam int KEYWORD_MAX_LEN = 7;
  localparam int KW_BITS         = 8 * KEYWORD_MAX_LEN;
  localparam int NUM_KEYWORDS    = 15;

  // Token kinds.
  localparam logic [5:0] TK_EOF        = 6'd0;
  localparam logic [5:0] TK_CONSTANT   = 6'd1;
  localparam logic [5:0] TK_IDENTIFIER = 6'd2;
  localparam logic [5:0] TK_KW_FIRST   = 6'd3;
  localparam logic [5:0] TK_COMMA      = 6'd18;
  localparam logic [5:0] TK_PERIOD     = 6'd19;
  localparam logic [5:0] TK_COLON      = 6'd20;
  localparam logic [5:0] TK_SEMI       = 6'd21;
  localparam logic [5:0] TK_EQUAL      = 6'd22;
  localparam logic [5:0] TK_PLUS       = 6'd23;
  localparam logic [5:0] TK_MINUS      = 6'd24;
  localparam logic [5:0] TK_STAR       = 6'd25;
  localparam logic [5:0] TK_LPAREN     = 6'd26;
  localparam logic [5:0] TK_RPAREN     = 6'd27;
  localparam logic [5:0] TK_LBRACK     = 6'd28;
  localparam logic [5:0] TK_RBRACK     = 6'd29;
  localparam logic [5:0] TK_GREATER    = 6'd30;
  localparam logic [5:0] TK_LESS       = 6'd31;
  localparam logic [5:0] TK_QUOTE      = 6'd32;
  localparam logic [5:0] TK_ASSIGN     = 6'd33;
  localparam logic [5:0] TK_EQ_EQ      = 6'd34;
  localparam logic [5:0] TK_GE         = 6'd35;
  localparam logic [5:0] TK_LE         = 6'd36;
  localparam logic [5:0] TK_NE         = 6'd37;
  localparam logic [5:0] TK_NONE       = 6'd0;

  // Keyword spellings, right-justified, with their lengths.
  localparam logic [KW_BITS-1:0] KwText [NUM_KEYWORDS] = '{
    KW_BITS'("program"), KW_BITS'("var"), KW_BITS'("begin"), KW_BITS'("integer"),
    KW_BITS'("boolean"), KW_BITS'("const"), KW_BITS'("end"), KW_BITS'("false"),
    KW_BITS'("true"), KW_BITS'("of"), KW_BITS'("div"), KW_BITS'("if"),
    KW_BITS'("else"), KW_BITS'("label"), KW_BITS'("goto")
  };
  localparam logic [3:0] KwLen [NUM_KEYWORDS] = '{
    4'd7, 4'd3, 4'd5, 4'd7, 4'd7, 4'd5, 4'd3, 4'd5, 4'd4, 4'd2,
    4'd3, 4'd2, 4'd4, 4'd5, 4'd4
  };

  // One result item.
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [31:0] value;
    logic        ovf;
    logic [7:0]  len;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // Kind of a single punctuation mark, TK_NONE for any other byte.
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      ",":     k = TK_COMMA;
      ".":     k = TK_PERIOD;
      ":":     k = TK_COLON;
      ";":     k = TK_SEMI;
      "=":     k = TK_EQUAL;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "[":     k = TK_LBRACK;
      "]":     k = TK_RBRACK;
      ">":     k = TK_GREATER;
      "<":     k = TK_LESS;
      8'h27:   k = TK_QUOTE;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

  // Word buffer holds character j in byte j; unused bytes are zero.
  function automatic logic [5:0] word_kind(input logic [KW_BITS-1:0] word,
                                           input logic [7:0] len);
    logic [5:0]         k;
    logic [KW_BITS-1:0] pat;
    k = TK_IDENTIFIER;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      pat = '0;
      for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
        if (j < int'(KwLen[i])) begin
          pat[8*j +: 8] = KwText[i][8*(int'(KwLen[i]) - 1 - j) +: 8];
        end
      end
      if ((len == {4'd0, KwLen[i]}) && (word == pat)) begin
        k = TK_KW_FIRST + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

### design/pascal_subset_tokenizer_unit.sv
// Pascal-subset tokenizer. Source bytes arrive one per input transfer and
// tokens leave one per output transfer. Whitespace separates tokens, LF
// advances the line count, digit runs become constants with a saturating
// value, letter-led alphanumeric runs become keywords or identifiers (only
// the length of an identifier is reported), and single and paired
// punctuation marks are recognized. An item with end_of_input flushes the
// pending token, emits EOF and returns the unit to its reset state, line
// count included. All the work for one item is done by the scanner logic
// between the token state registers and a three-entry result buffer, so
// an item is taken every cycle as long as it causes at most one token and
// the output is not stalled. An item that causes two or three tokens (a
// token ended by a mark, then EOF) holds the input while the result
// buffer drains, one token per output transfer; last_of_run marks the
// final token of each item.
module pascal_subset_tokenizer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_code_i,
  input  logic                has_char_i,
  input  logic                end_of_input_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          token_kind_o,
  output logic [15:0]         line_number_o,
  output logic [31:0]         constant_value_o,
  output logic                value_overflow_o,
  output logic [7:0]          lexeme_length_o,
  output logic                last_of_run_o
);
  import pst_pkg::*;

  // Scanner modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_WORD  = 2'd2;
  localparam logic [1:0] MODE_PUNCT = 2'd3;

  localparam logic [VALUE_BITS-1:0] ValueMax = {VALUE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LineMax  = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LineOne  = LINE_BITS'(1);

  // Token state.
  logic [1:0]            mode_q, mode_d;
  logic [5:0]            pend_q, pend_d;
  logic [KW_BITS-1:0]    word_q, word_d;
  logic [7:0]            len_q, len_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  sat_q, sat_d;
  logic [LINE_BITS-1:0]  line_q, line_d;

  // Result buffer: the tokens of the last item with a head pointer.
  result_t               slot_q [3];
  result_t               slot_d [3];
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            head_q;
  logic [1:0]            nres;

  logic                  in_xfer;
  logic                  out_xfer;
  logic                  buf_free;

  // The result a pending token turns into when it ends.
  function automatic result_t flush_result(input logic [1:0] mode,
                                           input logic [5:0] pend,
                                           input logic [KW_BITS-1:0] word,
                                           input logic [7:0] len,
                                           input logic [VALUE_BITS-1:0] acc,
                                           input logic sat,
                                           input logic [LINE_BITS-1:0] line);
    result_t                r;
    logic [VALUE_BITS+31:0] vext;
    logic [LINE_BITS+15:0]  lext;
    vext = {32'd0, acc};
    lext = {16'd0, line};
    r.line  = lext[15:0];
    r.value = '0;
    r.ovf   = 1'b0;
    r.len   = len;
    r.kind  = TK_NONE;
    unique case (mode)
      MODE_NUM: begin
        r.kind  = TK_CONSTANT;
        r.value = vext[31:0];
        r.ovf   = sat;
      end
      MODE_WORD:  r.kind = word_kind(word, len);
      MODE_PUNCT: begin
        r.kind = pend;
        r.len  = 8'd1;
      end
      default:    r.kind = TK_NONE;
    endcase
    return r;
  endfunction

  assign out_valid_o = (head_q != cnt_q);
  assign out_xfer    = out_valid_o && !out_stall_i;
  // The buffer can take a new item when empty or once its last entry leaves this cycle.
  assign buf_free    = !out_valid_o || ((head_q == cnt_q - 2'd1) && !out_stall_i);
  assign in_stall_o  = !buf_free;
  assign in_xfer     = in_valid_i && buf_free;

  always_comb begin
    logic [1:0]            mode;
    logic [5:0]            pend;
    logic [KW_BITS-1:0]    word;
    logic [7:0]            len;
    logic [VALUE_BITS-1:0] acc;
    logic                  sat;
    logic [LINE_BITS-1:0]  line;
    logic [1:0]            n;
    logic [5:0]            pair;
    logic [5:0]            pk;
    logic                  ends;
    logic                  starts;
    logic [VALUE_BITS+3:0] wide;
    logic [LINE_BITS+15:0] lext;
    logic [7:0]            c;

    mode = mode_q;
    pend = pend_q;
    word = word_q;
    len  = len_q;
    acc  = acc_q;
    sat  = sat_q;
    line = line_q;
    n    = 2'd0;
    c    = char_code_i;
    pk   = TK_NONE;
    wide = '0;
    for (int i = 0; i < 3; i++) begin
      slot_d[i] = slot_q[i];
    end

    // Pair completion of a pending mark.
    pair = TK_NONE;
    if (mode_q == MODE_PUNCT) begin
      if (c == "=") begin
        priority if (pend_q == TK_COLON)   pair = TK_ASSIGN;
        else if (pend_q == TK_EQUAL)       pair = TK_EQ_EQ;
        else if (pend_q == TK_GREATER)     pair = TK_GE;
        else if (pend_q == TK_LESS)        pair = TK_LE;
        else                               pair = TK_NONE;
      end else if ((c == ">") && (pend_q == TK_LESS)) begin
        pair = TK_NE;
      end
    end

    ends = has_char_i && (((mode_q == MODE_PUNCT) && (pair == TK_NONE)) ||
                          ((mode_q == MODE_NUM) && !is_digit(c)) ||
                          ((mode_q == MODE_WORD) && !is_digit(c) && !is_letter(c)));
    starts = has_char_i && (ends || (mode_q == MODE_IDLE));
    lext = {16'd0, line_q};

    if (has_char_i && (pair != TK_NONE)) begin
      slot_d[0] = '{kind: pair, line: lext[15:0], value: 32'd0, ovf: 1'b0, len: 8'd2};
      n    = 2'd1;
      mode = MODE_IDLE;
      pend = '0;
      len  = '0;
    end

    // Extending the current token.
    if (has_char_i && !ends && !starts && (mode_q == MODE_NUM)) begin
      wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (VALUE_BITS+4)'(c - "0");
      if (!sat) begin
        if (wide > {4'd0, ValueMax}) begin
          acc = ValueMax;
          sat = 1'b1;
        end else begin
          acc = wide[VALUE_BITS-1:0];
        end
      end
      if (len != 8'hFF) len = len + 8'd1;
    end
    if (has_char_i && !ends && !starts && (mode_q == MODE_WORD)) begin
      for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
        if (len == 8'(j)) word[8*j +: 8] = c;
      end
      if (len != 8'hFF) len = len + 8'd1;
    end

    if (ends) begin
      slot_d[0] = flush_result(mode_q, pend_q, word_q, len_q, acc_q, sat_q, line_q);
      n    = 2'd1;
      mode = MODE_IDLE;
      pend = '0;
      word = '0;
      len  = '0;
      acc  = '0;
      sat  = 1'b0;
    end

    // Scanning a byte from the idle mode.
    if (starts) begin
      pk = punct_kind(c);
      if (c == 8'h0A) begin
        if (line != LineMax) line = line + LineOne;
      end else if (is_digit(c)) begin
        mode = MODE_NUM;
        acc  = VALUE_BITS'(c - "0");
        len  = 8'd1;
      end else if (is_letter(c)) begin
        mode = MODE_WORD;
        word = '0;
        word[7:0] = c;
        len  = 8'd1;
      end else if ((c == ":") || (c == "=") || (c == ">") || (c == "<")) begin
        mode = MODE_PUNCT;
        pend = pk;
      end else if (pk != TK_NONE) begin
        slot_d[n] = '{kind: pk, line: lext[15:0], value: 32'd0, ovf: 1'b0, len: 8'd1};
        n = n + 2'd1;
      end
    end

    if (end_of_input_i) begin
      lext = {16'd0, line};
      if (mode != MODE_IDLE) begin
        slot_d[n] = flush_result(mode, pend, word, len, acc, sat, line);
        n = n + 2'd1;
      end
      slot_d[n] = '{kind: TK_EOF, line: lext[15:0], value: 32'd0, ovf: 1'b0, len: 8'd0};
      n    = n + 2'd1;
      mode = MODE_IDLE;
      pend = '0;
      word = '0;
      len  = '0;
      acc  = '0;
      sat  = 1'b0;
      line = LineOne;
    end

    mode_d = mode;
    pend_d = pend;
    word_d = word;
    len_d  = len;
    acc_d  = acc;
    sat_d  = sat;
    line_d = line;
    nres   = n;
    cnt_d  = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= '0;
      word_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      sat_q  <= 1'b0;
      line_q <= LineOne;
      cnt_q  <= 2'd0;
      head_q <= 2'd0;
    end else begin
      if (in_xfer) begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        word_q <= word_d;
        len_q  <= len_d;
        acc_q  <= acc_d;
        sat_q  <= sat_d;
        line_q <= line_d;
      end
      if (in_xfer && (nres != 2'd0)) begin
        cnt_q  <= cnt_d;
        head_q <= 2'd0;
      end else if (out_xfer) begin
        head_q <= head_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (nres != 2'd0)) begin
      for (int i = 0; i < 3; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  always_comb begin
    result_t r;
    r = slot_q[0];
    unique case (head_q)
      2'd0:    r = slot_q[0];
      2'd1:    r = slot_q[1];
      2'd2:    r = slot_q[2];
      default: r = slot_q[0];
    endcase
    token_kind_o     = r.kind;
    line_number_o    = r.line;
    constant_value_o = r.value;
    value_overflow_o = r.ovf;
    lexeme_length_o  = r.len;
    last_of_run_o    = (head_q == cnt_q - 2'd1);
  end

  // The head pointer never runs past the tokens of the current item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= cnt_q)
    else $error("result head past end of batch");

  // EOF is always the final token of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == TK_EOF)) |-> last_of_run_o)
    else $error("EOF not last of run");

  // Taking the last token with no new item leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_of_run_o && !in_xfer) |=> !out_valid_o)
    else $error("output valid after last token taken");

  // End of input returns the scanner to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && end_of_input_i) |=> ((line_q == LineOne) && (mode_q == MODE_IDLE)))
    else $error("state not cleared after end of input");

endmodule
